// ===== rtl/ttu_pkg.sv =====
// Shared types, constants and a helper function for the text-to-unsigned parser.
// No dependencies; every other file of the block imports this package.
package ttu_pkg;

  // Working width of the accumulator and saturation limit of the position count.
  localparam int VALUE_BITS     = 64;
  localparam int POSITION_LIMIT = 4095;

  // Fixed field widths on the ports.
  localparam int CHAR_W  = 8;
  localparam int BASE_W  = 6;
  localparam int VALUE_W = 64;
  localparam int END_W   = 12;

  // Position counter is wide enough for the limit and for the output field.
  localparam int POS_BITS = $clog2(POSITION_LIMIT + 1);
  localparam int POS_W    = (POS_BITS > END_W) ? POS_BITS : END_W;

  // Radix codes.
  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_ONE  = 6'd1;
  localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
  localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;

  localparam logic [BASE_W-1:0] NOT_A_DIGIT = '1;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;

  localparam logic [CHAR_W-1:0] ALPHA_OFS = 8'd10;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [END_W-1:0]   end_position;
    logic               converted;
    logic               overflowed;
    logic               bad_base;
  } res_t;

  // Digit value of a character in any radix up to 36, or NOT_A_DIGIT.
  function automatic logic [BASE_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [BASE_W-1:0] d;
    d = NOT_A_DIGIT;
    if (c >= CH_0 && c <= CH_9) begin
      d = BASE_W'(c - CH_0);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = BASE_W'(c - CH_LA + ALPHA_OFS);
    end else if (c >= CH_UA && c <= CH_UZ) begin
      d = BASE_W'(c - CH_UA + ALPHA_OFS);
    end
    return d;
  endfunction

endpackage

// ===== rtl/ttu_if.sv =====
// Handshake channel interfaces for the parser: character input, result output
// and base register write. Depends on ttu_pkg for field widths and types.
interface ttu_in_if import ttu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              first_char;

  modport source (output valid, output character, output first_char, input ready);
  modport sink   (input valid, input character, input first_char, output ready);
endinterface

interface ttu_out_if import ttu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic [END_W-1:0]   end_position;
  logic               converted;
  logic               overflowed;
  logic               bad_base;

  modport source (output valid, output value, output end_position, output converted,
                  output overflowed, output bad_base, input ready);
  modport sink   (input valid, input value, input end_position, input converted,
                  input overflowed, input bad_base, output ready);
endinterface

interface ttu_cfg_if import ttu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BASE_W-1:0] number_base;

  modport source (output valid, output number_base, input ready);
  modport sink   (input valid, input number_base, output ready);
endinterface

// ===== rtl/ttu_mac.sv =====
// Multiply-accumulate of the running value by the radix plus one digit.
// Depends on ttu_pkg for widths; purely combinational.
module ttu_mac import ttu_pkg::*; (
  input  logic [VALUE_BITS-1:0] acc,
  input  logic [BASE_W-1:0]     base,
  input  logic [BASE_W-1:0]     digit,
  output logic [VALUE_BITS-1:0] sum,
  output logic                  carry_out
);

  localparam int PROD_W = VALUE_BITS + BASE_W;

  logic [PROD_W-1:0] prod;

  // Any bit above the working width means the true value no longer fits.
  assign prod      = PROD_W'(acc) * PROD_W'(base) + PROD_W'(digit);
  assign sum       = prod[VALUE_BITS-1:0];
  assign carry_out = |prod[PROD_W-1:VALUE_BITS];

endmodule

// ===== rtl/ttu_parse.sv =====
// Parse state machine: whitespace, sign, prefix and digit phases, one character
// per step. Depends on ttu_pkg and instantiates ttu_mac.
module ttu_parse import ttu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [CHAR_W-1:0] character,
  input  logic              first_char,
  input  logic [BASE_W-1:0] cfg_base,
  output logic              emit,
  output res_t              res
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SPACE  = 3'd1;
  localparam logic [2:0] PH_PREFIX = 3'd2;
  localparam logic [2:0] PH_ZERO   = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;

  logic [2:0]            phase_r, phase_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic [BASE_W-1:0]     base_r, base_nxt;
  logic                  neg_r, neg_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  any_r, any_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;

  // State after the leading phases of this character, before digit handling.
  logic [2:0]            ph_a;
  logic [VALUE_BITS-1:0] acc_a;
  logic [BASE_W-1:0]     base_a;
  logic                  neg_a;
  logic                  ovf_a;
  logic                  any_a;
  logic [POS_W-1:0]      pos_a;
  logic                  do_prefix;
  logic                  do_digit;
  logic                  bad_first;

  logic [BASE_W-1:0]     digit;
  logic                  take;
  logic [VALUE_BITS-1:0] mac_sum;
  logic                  mac_ovf;
  logic [VALUE_BITS-1:0] neg_acc;

  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] p);
    return (p < POS_W'(POSITION_LIMIT)) ? p + POS_W'(1) : p;
  endfunction

  always_comb begin
    ph_a      = phase_r;
    acc_a     = acc_r;
    base_a    = base_r;
    neg_a     = neg_r;
    ovf_a     = ovf_r;
    any_a     = any_r;
    pos_a     = pos_r;
    do_prefix = 1'b0;
    do_digit  = 1'b0;
    bad_first = 1'b0;

    if (first_char) begin
      acc_a  = '0;
      neg_a  = 1'b0;
      ovf_a  = 1'b0;
      any_a  = 1'b0;
      pos_a  = '0;
      base_a = cfg_base;
      if (cfg_base == BASE_ONE || cfg_base > BASE_MAX) begin
        ph_a      = PH_IDLE;
        bad_first = 1'b1;
      end else begin
        ph_a = PH_SPACE;
      end
    end

    if (!bad_first) begin
      case (ph_a)
        PH_SPACE: begin
          if (character == CH_SPACE || character inside {[CH_TAB:CH_CR]}) begin
            pos_a = sat_inc(pos_a);
          end else if (character == CH_MINUS || character == CH_PLUS) begin
            neg_a = (character == CH_MINUS);
            pos_a = sat_inc(pos_a);
            ph_a  = PH_PREFIX;
          end else begin
            do_prefix = 1'b1;
          end
        end
        PH_PREFIX: begin
          do_prefix = 1'b1;
        end
        PH_ZERO: begin
          if (character == CH_LX || character == CH_UX) begin
            base_a = BASE_HEX;
            pos_a  = sat_inc(pos_a);
            ph_a   = PH_DIGITS;
          end else begin
            // In hex the lone zero counts as a converted digit; in auto mode it
            // selects octal and is only consumed.
            if (base_a == BASE_HEX) begin
              any_a = 1'b1;
              acc_a = '0;
            end else begin
              base_a = BASE_OCT;
            end
            ph_a     = PH_DIGITS;
            do_digit = 1'b1;
          end
        end
        PH_DIGITS: begin
          do_digit = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (do_prefix) begin
      if (character == CH_0 && (base_a == BASE_AUTO || base_a == BASE_HEX)) begin
        pos_a = sat_inc(pos_a);
        ph_a  = PH_ZERO;
      end else begin
        if (base_a == BASE_AUTO) begin
          base_a = BASE_DEC;
        end
        ph_a     = PH_DIGITS;
        do_digit = 1'b1;
      end
    end
  end

  assign digit   = digit_of(character);
  assign take    = do_digit && (digit < base_a);
  assign neg_acc = VALUE_BITS'(0) - acc_a;

  ttu_mac u_mac (
    .acc       (acc_a),
    .base      (base_a),
    .digit     (digit),
    .sum       (mac_sum),
    .carry_out (mac_ovf)
  );

  always_comb begin
    phase_nxt = ph_a;
    acc_nxt   = acc_a;
    base_nxt  = base_a;
    neg_nxt   = neg_a;
    ovf_nxt   = ovf_a;
    any_nxt   = any_a;
    pos_nxt   = pos_a;
    emit      = 1'b0;
    res       = '0;

    if (bad_first) begin
      emit         = 1'b1;
      res.bad_base = 1'b1;
    end else if (take) begin
      ovf_nxt = ovf_a | mac_ovf;
      acc_nxt = mac_sum;
      any_nxt = 1'b1;
      pos_nxt = sat_inc(pos_a);
    end else if (do_digit) begin
      // The first character that is not a digit closes the string.
      phase_nxt = PH_IDLE;
      emit      = 1'b1;
      if (any_a) begin
        res.converted    = 1'b1;
        res.end_position = pos_a[END_W-1:0];
        if (ovf_a) begin
          res.overflowed = 1'b1;
          res.value      = VALUE_W'({VALUE_BITS{1'b1}});
        end else if (neg_a) begin
          res.value = VALUE_W'(neg_acc);
        end else begin
          res.value = VALUE_W'(acc_a);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      acc_r   <= '0;
      base_r  <= '0;
      neg_r   <= 1'b0;
      ovf_r   <= 1'b0;
      any_r   <= 1'b0;
      pos_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      base_r  <= base_nxt;
      neg_r   <= neg_nxt;
      ovf_r   <= ovf_nxt;
      any_r   <= any_nxt;
      pos_r   <= pos_nxt;
    end
  end

endmodule

// ===== rtl/text_to_unsigned_parser.sv =====
// Streaming text-to-unsigned converter. One character is taken per transfer and
// the block sustains one transfer per cycle while the result channel is not
// stalled. A result passes from its closing character through the input register,
// then the parse step and the result register. The clock period is set by the
// combinational multiply-accumulate of the 64-bit running value by the radix. The base
// register is sampled when a string starts and may be written at any time with no wait cycles.
module text_to_unsigned_parser import ttu_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  ttu_in_if.sink    in_ch,
  ttu_out_if.source out_ch,
  ttu_cfg_if.sink   cfg_ch
);

  logic              in_valid_r;
  logic [CHAR_W-1:0] char_r;
  logic              first_r;
  logic [BASE_W-1:0] number_base_r;
  logic              out_valid_r;
  res_t              res_r;

  logic step;
  logic emit;
  res_t res;

  // The parse step runs when a character is held and the result register is free or being emptied.
  assign step         = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || step;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      char_r  <= in_ch.character;
      first_r <= in_ch.first_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_base_r <= BASE_AUTO;
    end else if (cfg_ch.valid) begin
      number_base_r <= cfg_ch.number_base;
    end
  end

  ttu_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .character  (char_r),
    .first_char (first_r),
    .cfg_base   (number_base_r),
    .emit       (emit),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.value        = res_r.value;
  assign out_ch.end_position = res_r.end_position;
  assign out_ch.converted    = res_r.converted;
  assign out_ch.overflowed   = res_r.overflowed;
  assign out_ch.bad_base     = res_r.bad_base;

  // A held character must survive a stalled result register.
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && out_valid_r && !out_ch.ready |=> in_valid_r && $stable(char_r))
    else $error("pending character lost while the result was stalled");

  a_bad_base_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.bad_base |->
      !res_r.converted && !res_r.overflowed && res_r.value == '0 &&
      res_r.end_position == '0)
    else $error("bad base result carries data");

  a_overflow_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.overflowed |->
      res_r.converted && res_r.value == VALUE_W'({VALUE_BITS{1'b1}}))
    else $error("overflow result is not all ones");

  a_unconverted_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.converted |-> res_r.value == '0 && res_r.end_position == '0)
    else $error("unconverted result is not zero");

endmodule

// ===== sim/tb_text_to_unsigned_parser.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for text_to_unsigned_parser: streams characters, predicts each
// parse result in a behavioural model and compares every transfer on the result channel.
// Depends on ttu_pkg, the channel interfaces in ttu_if.sv and the parser RTL.
module tb_text_to_unsigned_parser;
  import ttu_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int ITEM_TARGET   = 850;
  localparam int MAX_GAP       = 18;
  localparam int SETTLE_CYCLES = 8;
  localparam int NO_DIGIT      = 99;

  localparam logic [VALUE_W-1:0] ALL_ONES = '1;

  typedef enum logic [2:0] {
    PS_IDLE,
    PS_SPACE,
    PS_PREFIX,
    PS_ZERO,
    PS_DIGITS
  } parse_state_e;

  logic clk;
  logic rst_n;

  ttu_in_if  in_if ();
  ttu_out_if out_if ();
  ttu_cfg_if cfg_if ();

  text_to_unsigned_parser u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source),
    .cfg_ch (cfg_if.sink)
  );

  // Behavioural copy of the parser state and the base register.
  parse_state_e      parse_state = PS_IDLE;
  logic [63:0]       acc         = '0;
  logic [BASE_W-1:0] eff_base    = '0;
  logic              negative    = 1'b0;
  logic              ovf_seen    = 1'b0;
  logic              digit_seen  = 1'b0;
  logic [POS_W-1:0]  pos         = '0;
  logic [BASE_W-1:0] base_reg    = BASE_AUTO;

  res_t expected_results[$];

  bit steady = 1'b0;
  int err_count       = 0;
  int results_checked = 0;
  int chars_sent      = 0;
  int base_writes     = 0;
  int cycle_count     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               expected_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------- prediction

  function automatic int char_digit(logic [CHAR_W-1:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_LA && c <= CH_LZ) return int'(c - CH_LA) + 10;
    if (c >= CH_UA && c <= CH_UZ) return int'(c - CH_UA) + 10;
    return NO_DIGIT;
  endfunction

  task automatic expect_result(logic [VALUE_W-1:0] v, logic [END_W-1:0] p, logic conv,
                               logic ovf, logic bad);
    res_t r;
    r.value        = v;
    r.end_position = p;
    r.converted    = conv;
    r.overflowed   = ovf;
    r.bad_base     = bad;
    expected_results.push_back(r);
  endtask

  task automatic advance_pos();
    if (pos < POS_W'(POSITION_LIMIT)) pos++;
  endtask

  task automatic digit_step(logic [CHAR_W-1:0] c);
    int          d;
    logic [63:0] radix;
    d     = char_digit(c);
    radix = 64'(eff_base);
    if (d != NO_DIGIT && d < int'(eff_base)) begin
      if (acc > (ALL_ONES - 64'(d)) / radix) ovf_seen = 1'b1;
      acc        = acc * radix + 64'(d);
      digit_seen = 1'b1;
      advance_pos();
    end else begin
      parse_state = PS_IDLE;
      if (!digit_seen) begin
        expect_result('0, '0, 1'b0, 1'b0, 1'b0);
      end else if (ovf_seen) begin
        expect_result(ALL_ONES, END_W'(pos), 1'b1, 1'b1, 1'b0);
      end else begin
        expect_result(negative ? (64'd0 - acc) : acc, END_W'(pos), 1'b1, 1'b0, 1'b0);
      end
    end
  endtask

  task automatic prefix_step(logic [CHAR_W-1:0] c);
    if (c == CH_0 && (eff_base == BASE_AUTO || eff_base == BASE_HEX)) begin
      advance_pos();
      parse_state = PS_ZERO;
    end else begin
      if (eff_base == BASE_AUTO) eff_base = BASE_DEC;
      parse_state = PS_DIGITS;
      digit_step(c);
    end
  endtask

  task automatic parse_char(logic [CHAR_W-1:0] c, logic first);
    if (first) begin
      acc        = '0;
      negative   = 1'b0;
      ovf_seen   = 1'b0;
      digit_seen = 1'b0;
      pos        = '0;
      eff_base   = base_reg;
      parse_state = PS_SPACE;
    end
    if (first && (eff_base == BASE_ONE || eff_base > BASE_MAX)) begin
      parse_state = PS_IDLE;
      expect_result('0, '0, 1'b0, 1'b0, 1'b1);
    end else begin
      case (parse_state)
        PS_SPACE: begin
          if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            advance_pos();
          end else if (c == CH_MINUS || c == CH_PLUS) begin
            negative = (c == CH_MINUS);
            advance_pos();
            parse_state = PS_PREFIX;
          end else begin
            prefix_step(c);
          end
        end
        PS_PREFIX: prefix_step(c);
        PS_ZERO: begin
          if (c == CH_LX || c == CH_UX) begin
            eff_base = BASE_HEX;
            advance_pos();
            parse_state = PS_DIGITS;
          end else begin
            // In hex the lone zero already counts as a converted digit.
            if (eff_base == BASE_HEX) begin
              digit_seen = 1'b1;
              acc        = '0;
            end else begin
              eff_base = BASE_OCT;
            end
            parse_state = PS_DIGITS;
            digit_step(c);
          end
        end
        PS_DIGITS: digit_step(c);
        default: ;
      endcase
    end
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    res_t exp_res;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        $error("unexpected result: value %h, end_position %0d", out_if.value,
               out_if.end_position);
        err_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_if.value !== exp_res.value) begin
          $error("value: expected %h, got %h", exp_res.value, out_if.value);
          err_count++;
        end
        if (out_if.end_position !== exp_res.end_position) begin
          $error("end_position: expected %0d, got %0d", exp_res.end_position,
                 out_if.end_position);
          err_count++;
        end
        if (out_if.converted !== exp_res.converted) begin
          $error("converted: expected %b, got %b", exp_res.converted, out_if.converted);
          err_count++;
        end
        if (out_if.overflowed !== exp_res.overflowed) begin
          $error("overflowed: expected %b, got %b", exp_res.overflowed, out_if.overflowed);
          err_count++;
        end
        if (out_if.bad_base !== exp_res.bad_base) begin
          $error("bad_base: expected %b, got %b", exp_res.bad_base, out_if.bad_base);
          err_count++;
        end
      end
    end
  end

  // Result channel back-pressure: a fresh stall is drawn after every transfer.
  initial begin
    int gap;
    out_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------- stimulus

  // Valid is only dropped ahead of a gap, so back-to-back transfers never see
  // a low and a high assignment in the same time step.
  task automatic send_char(logic [CHAR_W-1:0] c, logic first);
    int gap;
    gap = steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.character  <= c;
    in_if.first_char <= first;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    parse_char(c, first);
    chars_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0);
  endtask

  // Closes any open string with a NUL, then holds off until every result is back.
  task automatic drain_results();
    send_char(8'h00, 1'b0);
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_base(logic [BASE_W-1:0] b);
    drain_results();
    cfg_if.valid       <= 1'b1;
    cfg_if.number_base <= b;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    base_reg = b;
    base_writes++;
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_random_string();
    logic [CHAR_W-1:0] text[$];
    int                kind, radix, n_dig, style, d, r;
    bit                nonzero_lead;
    kind         = $urandom_range(0, 19);
    radix        = 10;
    nonzero_lead = 1'b0;
    if (kind < 2) begin
      // Noise: arbitrary bytes, occasionally restarting.
      r = $urandom_range(1, 6);
      for (int i = 0; i < r; i++) begin
        send_char(CHAR_W'($urandom_range(0, 255)), i == 0 || $urandom_range(0, 3) == 0);
      end
    end else begin
      if ($urandom_range(0, 1)) begin
        repeat ($urandom_range(1, 3)) begin
          r = $urandom_range(0, 5);
          text.push_back(r == 0 ? CH_SPACE : CHAR_W'(CH_TAB + r - 1));
        end
      end
      r = $urandom_range(0, 2);
      if (r == 1) text.push_back(CH_PLUS);
      if (r == 2) text.push_back(CH_MINUS);
      if (base_reg == BASE_AUTO) begin
        style = $urandom_range(0, 2);
        if (style == 0) begin
          text.push_back(CH_0);
          text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
          radix = 16;
        end else if (style == 1) begin
          text.push_back(CH_0);
          radix = 8;
        end else begin
          nonzero_lead = 1'b1;
        end
      end else if (base_reg == BASE_HEX) begin
        radix = 16;
        if ($urandom_range(0, 1)) begin
          text.push_back(CH_0);
          text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
        end
      end else if (base_reg != BASE_ONE && base_reg <= BASE_MAX) begin
        radix = int'(base_reg);
      end
      n_dig = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 70) : $urandom_range(0, 12);
      for (int i = 0; i < n_dig; i++) begin
        d = (nonzero_lead && i == 0) ? $urandom_range(1, 9) : $urandom_range(0, radix - 1);
        if (d < 10) begin
          text.push_back(CHAR_W'(CH_0 + d));
        end else begin
          text.push_back(CHAR_W'(($urandom_range(0, 1) ? CH_LA : CH_UA) + d - 10));
        end
      end
      r = $urandom_range(0, 3);
      text.push_back(r == 0 ? 8'h00 : (r == 1 ? CH_SPACE : CHAR_W'($urandom_range(0, 255))));
      // A broken string is cut short and left for the next start to abandon.
      if (kind == 2) begin
        r = $urandom_range(1, text.size());
        while (text.size() > r) void'(text.pop_back());
      end
      foreach (text[i]) send_char(text[i], i == 0);
      repeat ($urandom_range(0, 2)) send_char(CHAR_W'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_idle_bytes();
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(CH_9, 1'b0);
  endtask

  // The register resets to automatic detection, so no write is needed here.
  task automatic test_auto_base();
    send_text(" \t-0x1F");
    send_char(8'h00, 1'b0);
    send_text("0777!");
    send_text("0");
    send_char(8'h00, 1'b0);
    send_text("0xg");
    send_text("+42 9");
    send_text("12");
    send_text("7;");
  endtask

  task automatic test_bad_base();
    set_base(BASE_ONE);
    send_text("5");
    send_char(8'hFF, 1'b1);
    set_base(BASE_MAX + 6'd1);
    send_text("9");
    set_base('1);
    send_text("0");
  endtask

  task automatic test_fixed_bases();
    set_base(BASE_HEX);
    send_text("0 ");
    send_text("0Xff.");
    send_text("0x");
    send_char(8'h00, 1'b0);
    set_base(6'd2);
    send_text("1012");
    set_base(BASE_MAX);
    send_text("zZ{");
    set_base(BASE_DEC);
    send_text("18446744073709551615 ");
    send_text("18446744073709551616 ");
    send_text("-0x5");
  endtask

  task automatic test_random_streams();
    logic [BASE_W-1:0] b;
    int                r, batch;
    while (chars_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 11);
      case (r)
        0, 1, 2, 3: b = BASE_AUTO;
        4:          b = BASE_HEX;
        5:          b = BASE_DEC;
        6:          b = 6'd2;
        7:          b = BASE_MAX;
        8:          b = BASE_OCT;
        10:         b = BASE_W'($urandom_range(0, 63));
        default:    b = BASE_W'($urandom_range(2, 36));
      endcase
      set_base(b);
      steady = ($urandom_range(0, 4) == 0);
      batch  = (b == BASE_ONE || b > BASE_MAX) ? 3 : $urandom_range(5, 15);
      for (int i = 0; i < batch && chars_sent < ITEM_TARGET; i++) send_random_string();
    end
    steady = 1'b0;
  endtask

  initial begin
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.character    <= '0;
    in_if.first_char   <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.number_base <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_bytes();
    test_auto_base();
    test_bad_base();
    test_fixed_bases();
    test_random_streams();
    drain_results();

    $display("Sent %0d characters across %0d base settings and checked %0d results,",
             chars_sent, base_writes + 1, results_checked);
    $display("covering prefixes, signs, overflow, invalid bases and random stalls.");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ttu_pkg.sv
rtl/ttu_if.sv
rtl/ttu_mac.sv
rtl/ttu_parse.sv
rtl/text_to_unsigned_parser.sv
sim/tb_text_to_unsigned_parser.sv
